// File: rtl/core/rtnh_pkg.sv
// ----------------------------------------------------------------------------
// rtnh_pkg
// Shared types, constants and the multiply program for the ray-triangle
// nearest hit core.
// ----------------------------------------------------------------------------
package rtnh_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int DIST_W          = 31;
	localparam int BARY_W          = 17;
	localparam int CFG_IDX_W       = 3;
	localparam int MUL_CHUNK       = 16;
	localparam int PROG_W          = 5;
	localparam logic [PROG_W-1:0] PROG_DOT_END = PROG_W'(23);
	localparam logic [PROG_W-1:0] PROG_END     = PROG_W'(26);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X = 3'd0,
		CFG_ORIGIN_Y = 3'd1,
		CFG_ORIGIN_Z = 3'd2,
		CFG_DIR_X    = 3'd3,
		CFG_DIR_Y    = 3'd4,
		CFG_DIR_Z    = 3'd5,
		CFG_MAX_DIST = 3'd6
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_E1X, OP_E1Y, OP_E1Z,
		OP_E2X, OP_E2Y, OP_E2Z,
		OP_SX,  OP_SY,  OP_SZ,
		OP_NX,  OP_NY,  OP_NZ,
		OP_QX,  OP_QY,  OP_QZ,
		OP_DX,  OP_DY,  OP_DZ,
		OP_NU,  OP_NV,  OP_NT,
		OP_RC
	} opnd_t;

	typedef enum logic [3:0] {
		DST_NX, DST_NY, DST_NZ,
		DST_QX, DST_QY, DST_QZ,
		DST_DEN, DST_NU, DST_NV, DST_NT,
		DST_U, DST_V, DST_T
	} dst_t;

	typedef enum logic [1:0] {
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_t;

	typedef struct packed {
		opnd_t a;
		opnd_t b;
		acc_t  op;
		logic  fin;
		logic  neg;
		dst_t  dst;
	} prog_t;

	typedef struct packed {
		logic              load;
		logic              mul_start;
		logic [PROG_W-1:0] prog_idx;
		logic              div_start;
		logic              commit;
		logic              emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic mul_done;
		logic div_busy;
		logic div_done;
		logic den_zero;
		logic last;
		logic out_free;
	} dp_sts_t;

	function automatic prog_t prog_entry(input logic [PROG_W-1:0] idx);
		prog_t p;
		p = '{a: OP_E1Y, b: OP_E2Z, op: ACC_LOAD, fin: 1'b0, neg: 1'b0, dst: DST_NX};
		case (idx)
			5'd0:  p = '{OP_E1Y, OP_E2Z, ACC_LOAD, 1'b0, 1'b0, DST_NX};
			5'd1:  p = '{OP_E1Z, OP_E2Y, ACC_SUB,  1'b1, 1'b0, DST_NX};
			5'd2:  p = '{OP_E1Z, OP_E2X, ACC_LOAD, 1'b0, 1'b0, DST_NY};
			5'd3:  p = '{OP_E1X, OP_E2Z, ACC_SUB,  1'b1, 1'b0, DST_NY};
			5'd4:  p = '{OP_E1X, OP_E2Y, ACC_LOAD, 1'b0, 1'b0, DST_NZ};
			5'd5:  p = '{OP_E1Y, OP_E2X, ACC_SUB,  1'b1, 1'b0, DST_NZ};
			5'd6:  p = '{OP_SY,  OP_DZ,  ACC_LOAD, 1'b0, 1'b0, DST_QX};
			5'd7:  p = '{OP_SZ,  OP_DY,  ACC_SUB,  1'b1, 1'b0, DST_QX};
			5'd8:  p = '{OP_SZ,  OP_DX,  ACC_LOAD, 1'b0, 1'b0, DST_QY};
			5'd9:  p = '{OP_SX,  OP_DZ,  ACC_SUB,  1'b1, 1'b0, DST_QY};
			5'd10: p = '{OP_SX,  OP_DY,  ACC_LOAD, 1'b0, 1'b0, DST_QZ};
			5'd11: p = '{OP_SY,  OP_DX,  ACC_SUB,  1'b1, 1'b0, DST_QZ};
			5'd12: p = '{OP_DX,  OP_NX,  ACC_LOAD, 1'b0, 1'b0, DST_DEN};
			5'd13: p = '{OP_DY,  OP_NY,  ACC_ADD,  1'b0, 1'b0, DST_DEN};
			5'd14: p = '{OP_DZ,  OP_NZ,  ACC_ADD,  1'b1, 1'b0, DST_DEN};
			5'd15: p = '{OP_QX,  OP_E2X, ACC_LOAD, 1'b0, 1'b0, DST_NU};
			5'd16: p = '{OP_QY,  OP_E2Y, ACC_ADD,  1'b0, 1'b0, DST_NU};
			5'd17: p = '{OP_QZ,  OP_E2Z, ACC_ADD,  1'b1, 1'b1, DST_NU};
			5'd18: p = '{OP_QX,  OP_E1X, ACC_LOAD, 1'b0, 1'b0, DST_NV};
			5'd19: p = '{OP_QY,  OP_E1Y, ACC_ADD,  1'b0, 1'b0, DST_NV};
			5'd20: p = '{OP_QZ,  OP_E1Z, ACC_ADD,  1'b1, 1'b0, DST_NV};
			5'd21: p = '{OP_NX,  OP_SX,  ACC_LOAD, 1'b0, 1'b0, DST_NT};
			5'd22: p = '{OP_NY,  OP_SY,  ACC_ADD,  1'b0, 1'b0, DST_NT};
			5'd23: p = '{OP_NZ,  OP_SZ,  ACC_ADD,  1'b1, 1'b1, DST_NT};
			5'd24: p = '{OP_NU,  OP_RC,  ACC_LOAD, 1'b1, 1'b0, DST_U};
			5'd25: p = '{OP_NV,  OP_RC,  ACC_LOAD, 1'b1, 1'b0, DST_V};
			5'd26: p = '{OP_NT,  OP_RC,  ACC_LOAD, 1'b1, 1'b0, DST_T};
			default: p = '{OP_E1Y, OP_E2Z, ACC_LOAD, 1'b0, 1'b0, DST_NX};
		endcase
		return p;
	endfunction

endpackage

// File: rtl/core/rtnh_ctrl.sv
// ----------------------------------------------------------------------------
// rtnh_ctrl
// Sequencer: steps the multiply program, launches the reciprocal, commits
// the hit and hands the word to the output register.
// ----------------------------------------------------------------------------
module rtnh_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rtnh_pkg::dp_sts_t     sts,
	output rtnh_pkg::ctrl_cmd_t   cmd
);
	import rtnh_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_MSTART = 7'b0000010,
		S_MWAIT  = 7'b0000100,
		S_DSTART = 7'b0001000,
		S_DWAIT  = 7'b0010000,
		S_COMMIT = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [PROG_W-1:0] pc_q, pc_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		pc_d    = pc_q;
		cmd     = '0;
		cmd.prog_idx = pc_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					pc_d     = '0;
					state_d  = S_MSTART;
				end
			end
			S_MSTART: begin
				cmd.mul_start = 1'b1;
				state_d       = S_MWAIT;
			end
			S_MWAIT: begin
				if (sts.mul_done) begin
					if (pc_q == PROG_DOT_END) begin
						state_d = S_DSTART;
					end else if (pc_q == PROG_END) begin
						state_d = S_COMMIT;
					end else begin
						pc_d    = pc_q + PROG_W'(1);
						state_d = S_MSTART;
					end
				end
			end
			S_DSTART: begin
				if (sts.den_zero) begin
					state_d = sts.last ? S_EMIT : S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DWAIT;
				end
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					pc_d    = pc_q + PROG_W'(1);
					state_d = S_MSTART;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = sts.last ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy && !sts.div_busy)
		else $error("multiply launched while a unit is busy");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.den_zero)
		else $error("reciprocal launched on zero denominator");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free && sts.last)
		else $error("word emitted into a full output register");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");

endmodule

// File: rtl/core/rtnh_dp.sv
// ----------------------------------------------------------------------------
// rtnh_dp
// Datapath: ray registers, edge vectors, shared chunked multiplier with
// accumulator, restoring reciprocal divider, nearest hit and output word.
// ----------------------------------------------------------------------------
module rtnh_dp #(
	parameter int COORD_WIDTH = rtnh_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rtnh_pkg::FRAC_BITS_DEF,
	parameter int CFG_W       = (COORD_WIDTH > rtnh_pkg::DIST_W) ? COORD_WIDTH
		: rtnh_pkg::DIST_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rtnh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data,
	input  logic signed [COORD_WIDTH-1:0]     a_x,
	input  logic signed [COORD_WIDTH-1:0]     a_y,
	input  logic signed [COORD_WIDTH-1:0]     a_z,
	input  logic signed [COORD_WIDTH-1:0]     b_x,
	input  logic signed [COORD_WIDTH-1:0]     b_y,
	input  logic signed [COORD_WIDTH-1:0]     b_z,
	input  logic signed [COORD_WIDTH-1:0]     c_x,
	input  logic signed [COORD_WIDTH-1:0]     c_y,
	input  logic signed [COORD_WIDTH-1:0]     c_z,
	input  logic                              last_triangle,
	input  rtnh_pkg::ctrl_cmd_t               cmd,
	output rtnh_pkg::dp_sts_t                 sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [rtnh_pkg::DIST_W-1:0]       distance,
	output logic [rtnh_pkg::BARY_W-1:0]       bary_u,
	output logic [rtnh_pkg::BARY_W-1:0]       bary_v,
	output logic [rtnh_pkg::BARY_W-1:0]       bary_w
);
	import rtnh_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int QW   = 2 * FRAC_BITS + 1;
	localparam int MW   = (W > QW) ? W : QW;
	localparam int NCH  = (MW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int BPW  = NCH * MUL_CHUNK;
	localparam int PW   = MW + BPW;
	localparam int XW   = (PW > 64) ? PW : 64;
	localparam int CW   = $clog2(NCH + 1);
	localparam int DCW  = $clog2(QW + 1);
	localparam logic [61:0]        MAG_LIM = 62'd1 << 61;
	localparam logic signed [63:0] SMAX    = (64'sd1 <<< (W - 1)) - 64'sd1;
	localparam logic signed [63:0] SMIN    = -SMAX - 64'sd1;
	localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FRAC_BITS;

	logic signed [W-1:0] org_q [3];
	logic signed [W-1:0] dir_q [3];
	logic [DIST_W-1:0]   max_dist_q;

	logic signed [W-1:0] e1_q [3];
	logic signed [W-1:0] e2_q [3];
	logic signed [W-1:0] s_q  [3];
	logic signed [W-1:0] n_q  [3];
	logic signed [W-1:0] qv_q [3];
	logic signed [W-1:0] den_q, nu_q, nv_q, nt_q;
	logic signed [63:0]  u_q, v_q, t_q;
	logic                last_q;

	prog_t               ent_q, ent_d;
	logic [MW-1:0]       am_q;
	logic [BPW-1:0]      bm_q;
	logic                mneg_q;
	logic [PW-1:0]       prod_q;
	logic [CW-1:0]       cnt_q;
	logic                mbusy_q, mdone_q;
	logic signed [63:0]  acc_q;

	logic [W-1:0]        dmag_q;
	logic [W-1:0]        rem_q;
	logic [QW-1:0]       quo_q;
	logic [DCW-1:0]      dcnt_q;
	logic                dbusy_q, ddone_q;

	logic [DIST_W-1:0]   near_dist_q;
	logic [BARY_W-1:0]   near_u_q, near_v_q, near_w_q;
	logic                any_hit_q;
	logic                out_valid_q;

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] x,
		input logic signed [W-1:0] y);
		logic signed [W:0] d;
		d = {x[W-1], x} - {y[W-1], y};
		if (d[W] != d[W-1])
			return d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		return d[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] x);
		if (x > SMAX)
			return W'(SMAX);
		if (x < SMIN)
			return W'(SMIN);
		return W'(x);
	endfunction

	function automatic logic signed [W-1:0] opnd_val(input opnd_t o);
		case (o)
			OP_E1X: return e1_q[0];
			OP_E1Y: return e1_q[1];
			OP_E1Z: return e1_q[2];
			OP_E2X: return e2_q[0];
			OP_E2Y: return e2_q[1];
			OP_E2Z: return e2_q[2];
			OP_SX:  return s_q[0];
			OP_SY:  return s_q[1];
			OP_SZ:  return s_q[2];
			OP_NX:  return n_q[0];
			OP_NY:  return n_q[1];
			OP_NZ:  return n_q[2];
			OP_QX:  return qv_q[0];
			OP_QY:  return qv_q[1];
			OP_QZ:  return qv_q[2];
			OP_DX:  return dir_q[0];
			OP_DY:  return dir_q[1];
			OP_DZ:  return dir_q[2];
			OP_NU:  return nu_q;
			OP_NV:  return nv_q;
			OP_NT:  return nt_q;
			default: return '0;
		endcase
	endfunction

	function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] x);
		return x[W-1] ? W'(-x) : W'(x);
	endfunction

	// operand magnitudes and signs at launch
	logic signed [W-1:0] va, vb;
	logic [MW-1:0]       ma, mb;
	logic                sa, sb;

	always_comb begin
		ent_d = prog_entry(cmd.prog_idx);
		va    = opnd_val(ent_d.a);
		vb    = opnd_val(ent_d.b);
		ma    = MW'(mag_w(va));
		sa    = va[W-1];
		if (ent_d.b == OP_RC) begin
			mb = MW'(quo_q);
			sb = den_q[W-1];
		end else begin
			mb = MW'(mag_w(vb));
			sb = vb[W-1];
		end
	end

	// finish of one product: drop fraction, clamp, sign, accumulate
	logic [XW-1:0]       shx;
	logic [61:0]         tmag;
	logic signed [63:0]  term, acc_n, fin_v;
	logic signed [W-1:0] fin_w;

	always_comb begin
		shx   = XW'(prod_q >> FRAC_BITS);
		tmag  = (shx > XW'(MAG_LIM)) ? MAG_LIM : shx[61:0];
		term  = mneg_q ? -$signed({2'b00, tmag}) : $signed({2'b00, tmag});
		case (ent_q.op)
			ACC_ADD: acc_n = acc_q + term;
			ACC_SUB: acc_n = acc_q - term;
			default: acc_n = term;
		endcase
		fin_v = ent_q.neg ? -acc_n : acc_n;
		fin_w = sat_w(fin_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
		end else begin
			mdone_q <= 1'b0;
			if (cmd.mul_start) begin
				mbusy_q <= 1'b1;
			end else if (mbusy_q && cnt_q == '0) begin
				mbusy_q <= 1'b0;
				mdone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			ent_q  <= ent_d;
			am_q   <= ma;
			bm_q   <= BPW'(mb);
			mneg_q <= sa ^ sb;
			prod_q <= '0;
			cnt_q  <= CW'(NCH);
		end else if (mbusy_q) begin
			if (cnt_q != '0) begin
				prod_q <= (prod_q << MUL_CHUNK)
					+ (PW'(am_q) * PW'(bm_q[BPW-1 -: MUL_CHUNK]));
				bm_q   <= bm_q << MUL_CHUNK;
				cnt_q  <= cnt_q - CW'(1);
			end else begin
				acc_q <= acc_n;
				if (ent_q.fin) begin
					case (ent_q.dst)
						DST_NX:  n_q[0]  <= fin_w;
						DST_NY:  n_q[1]  <= fin_w;
						DST_NZ:  n_q[2]  <= fin_w;
						DST_QX:  qv_q[0] <= fin_w;
						DST_QY:  qv_q[1] <= fin_w;
						DST_QZ:  qv_q[2] <= fin_w;
						DST_DEN: den_q   <= fin_w;
						DST_NU:  nu_q    <= fin_w;
						DST_NV:  nv_q    <= fin_w;
						DST_NT:  nt_q    <= fin_w;
						DST_U:   u_q     <= fin_v;
						DST_V:   v_q     <= fin_v;
						DST_T:   t_q     <= fin_v;
						default: acc_q   <= acc_n;
					endcase
				end
			end
		end
	end

	// restoring divider: 2^(2F) / |den|, one quotient bit a cycle
	logic [W:0] r2;
	assign r2 = {rem_q, (dcnt_q == DCW'(QW))};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
			end else if (dbusy_q && dcnt_q == DCW'(1)) begin
				dbusy_q <= 1'b0;
				ddone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dmag_q <= mag_w(den_q);
			rem_q  <= '0;
			quo_q  <= '0;
			dcnt_q <= DCW'(QW);
		end else if (dbusy_q) begin
			if (r2 >= {1'b0, dmag_q}) begin
				rem_q <= W'(r2 - {1'b0, dmag_q});
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= W'(r2);
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - DCW'(1);
		end
	end

	// edges at accept
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e1_q[0] <= sat_sub(b_x, a_x);
			e1_q[1] <= sat_sub(b_y, a_y);
			e1_q[2] <= sat_sub(b_z, a_z);
			e2_q[0] <= sat_sub(c_x, a_x);
			e2_q[1] <= sat_sub(c_y, a_y);
			e2_q[2] <= sat_sub(c_z, a_z);
			s_q[0]  <= sat_sub(org_q[0], a_x);
			s_q[1]  <= sat_sub(org_q[1], a_y);
			s_q[2]  <= sat_sub(org_q[2], a_z);
			last_q  <= last_triangle;
		end
	end

	// hit test
	logic signed [63:0] uv_sum, w_full;
	logic               in_tri, t_ok, hit_ok;

	always_comb begin
		uv_sum = u_q + v_q;
		w_full = ONE_Q - u_q - v_q;
		in_tri = !(u_q < 0 || u_q > ONE_Q || v_q < 0 || v_q > ONE_Q || uv_sum > ONE_Q);
		t_ok   = (t_q > 0) && (t_q < $signed({33'd0, near_dist_q}));
		hit_ok = in_tri && t_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0]    <= '0;
			org_q[1]    <= '0;
			org_q[2]    <= '0;
			dir_q[0]    <= W'(ONE_Q);
			dir_q[1]    <= '0;
			dir_q[2]    <= '0;
			max_dist_q  <= '1;
			near_dist_q <= '1;
			near_u_q    <= '0;
			near_v_q    <= '0;
			near_w_q    <= '0;
			any_hit_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIGIN_X: org_q[0] <= cfg_data[W-1:0];
					CFG_ORIGIN_Y: org_q[1] <= cfg_data[W-1:0];
					CFG_ORIGIN_Z: org_q[2] <= cfg_data[W-1:0];
					CFG_DIR_X:    dir_q[0] <= cfg_data[W-1:0];
					CFG_DIR_Y:    dir_q[1] <= cfg_data[W-1:0];
					CFG_DIR_Z:    dir_q[2] <= cfg_data[W-1:0];
					CFG_MAX_DIST: begin
						max_dist_q <= cfg_data[DIST_W-1:0];
						if (!any_hit_q)
							near_dist_q <= cfg_data[DIST_W-1:0];
					end
					default: max_dist_q <= max_dist_q;
				endcase
			end
			if (cmd.commit && hit_ok) begin
				near_dist_q <= t_q[DIST_W-1:0];
				near_u_q    <= u_q[BARY_W-1:0];
				near_v_q    <= v_q[BARY_W-1:0];
				near_w_q    <= w_full[BARY_W-1:0];
				any_hit_q   <= 1'b1;
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				near_dist_q <= max_dist_q;
				near_u_q    <= '0;
				near_v_q    <= '0;
				near_w_q    <= '0;
				any_hit_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hit      <= any_hit_q;
			distance <= near_dist_q;
			bary_u   <= near_u_q;
			bary_v   <= near_v_q;
			bary_w   <= near_w_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts          = '0;
		sts.mul_busy = mbusy_q;
		sts.mul_done = mdone_q;
		sts.div_busy = dbusy_q;
		sts.div_done = ddone_q;
		sts.den_zero = (den_q == '0);
		sts.last     = last_q;
		sts.out_free = !out_valid_q || out_ready;
	end

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mbusy_q && dbusy_q))
		else $error("multiplier and divider busy together");
	a_miss_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!any_hit_q |-> near_u_q == '0 && near_v_q == '0 && near_w_q == '0)
		else $error("barycentrics held without a hit");
	a_emit_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !any_hit_q && out_valid_q)
		else $error("re-arm after emit failed");

endmodule

// File: rtl/core/ray_triangle_nearest_hit_core.sv
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_core
// Nearest ray-triangle hit over a run of triangles, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One triangle word is taken at a time. Each triangle runs 27 fixed-point
// products through one shared multiplier, which works in 16-bit chunks and
// has a launch and a writeback around each product, and one reciprocal
// through a restoring divider with a 2F+1 bit quotient. A zero denominator
// skips the reciprocal and the last three products. The result word of a
// ray is held in an output register, so the next triangle is taken while it
// waits.
module ray_triangle_nearest_hit_core #(
	parameter int COORD_WIDTH = rtnh_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rtnh_pkg::FRAC_BITS_DEF,
	parameter int CFG_W       = (COORD_WIDTH > rtnh_pkg::DIST_W) ? COORD_WIDTH
		: rtnh_pkg::DIST_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rtnh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COORD_WIDTH-1:0]     a_x,
	input  logic signed [COORD_WIDTH-1:0]     a_y,
	input  logic signed [COORD_WIDTH-1:0]     a_z,
	input  logic signed [COORD_WIDTH-1:0]     b_x,
	input  logic signed [COORD_WIDTH-1:0]     b_y,
	input  logic signed [COORD_WIDTH-1:0]     b_z,
	input  logic signed [COORD_WIDTH-1:0]     c_x,
	input  logic signed [COORD_WIDTH-1:0]     c_y,
	input  logic signed [COORD_WIDTH-1:0]     c_z,
	input  logic                              last_triangle,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [rtnh_pkg::DIST_W-1:0]       distance,
	output logic [rtnh_pkg::BARY_W-1:0]       bary_u,
	output logic [rtnh_pkg::BARY_W-1:0]       bary_v,
	output logic [rtnh_pkg::BARY_W-1:0]       bary_w
);
	import rtnh_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	rtnh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rtnh_dp #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.CFG_W       (CFG_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.a_x           (a_x),
		.a_y           (a_y),
		.a_z           (a_z),
		.b_x           (b_x),
		.b_y           (b_y),
		.b_z           (b_z),
		.c_x           (c_x),
		.c_y           (c_y),
		.c_z           (c_z),
		.last_triangle (last_triangle),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.distance      (distance),
		.bary_u        (bary_u),
		.bary_v        (bary_v),
		.bary_w        (bary_w)
	);

endmodule

// File: sim/ray_triangle_nearest_hit_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_core_test
// Self-checking bench for the ray-triangle nearest hit core. Triangle words
// are sent through the input handshake while a fixed-point predictor tracks
// the nearest hit of each ray; every result word is checked field by field.
// Directed tests cover the default ray, extreme values, degenerate triangles,
// equal distances, the distance bound and ray changes mid-ray, then random
// rays with triangles mostly scattered around a point on the ray and some noise.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit_core_test;
	import rtnh_pkg::*;

	localparam longint ONE_Q     = 64'sd65536;
	localparam longint MAG_CLAMP = 64'sd1 <<< 61;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES  = 450;

	typedef logic signed [31:0] tri_words_t [9];
	typedef struct {
		longint x, y, z;
	} vec3_t;
	typedef struct {
		logic        hit;
		logic [30:0] distance;
		logic [16:0] u, v, w;
	} ray_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
	logic signed [31:0] c_x = 0, c_y = 0, c_z = 0;
	logic last_triangle = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic [30:0] distance;
	logic [16:0] bary_u, bary_v, bary_w;

	// ray registers and nearest hit as the predictor sees them
	vec3_t       ray_org, ray_dir;
	logic [30:0] dist_bound, near_dist;
	longint      near_u, near_v;
	bit          near_any;

	ray_result_t pending_results[$];
	int errors = 0;
	int tris_sent = 0, words_checked = 0, hits_seen = 0;
	int idle_cycles = 0;
	int out_stall = 0;
	bit calm = 1'b0;

	ray_triangle_nearest_hit_core dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint qmul(longint a, longint b);
		logic [63:0]  ma, mb;
		logic [127:0] p;
		longint       m;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = ({64'd0, ma} * {64'd0, mb}) >> 16;
		m = (p > 128'(MAG_CLAMP)) ? MAG_CLAMP : longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic vec3_t vsub(vec3_t a, vec3_t b);
		vec3_t r;
		r.x = sat32(a.x - b.x);
		r.y = sat32(a.y - b.y);
		r.z = sat32(a.z - b.z);
		return r;
	endfunction

	function automatic vec3_t vcross(vec3_t a, vec3_t b);
		vec3_t r;
		r.x = sat32(qmul(a.y, b.z) - qmul(a.z, b.y));
		r.y = sat32(qmul(a.z, b.x) - qmul(a.x, b.z));
		r.z = sat32(qmul(a.x, b.y) - qmul(a.y, b.x));
		return r;
	endfunction

	function automatic longint vdot(vec3_t a, vec3_t b);
		return qmul(a.x, b.x) + qmul(a.y, b.y) + qmul(a.z, b.z);
	endfunction

	function automatic tri_words_t tri9(longint ax, ay, az, bx, by, bz, cx, cy, cz);
		tri_words_t t;
		t = '{32'(ax), 32'(ay), 32'(az), 32'(bx), 32'(by), 32'(bz),
			32'(cx), 32'(cy), 32'(cz)};
		return t;
	endfunction

	task automatic fold_triangle(tri_words_t t);
		vec3_t  a, b, c, e1, e2, s, n, q;
		longint den, nu, nv, nt, recip, u, v, t_hit;
		logic [63:0] rm;
		a = '{longint'(t[0]), longint'(t[1]), longint'(t[2])};
		b = '{longint'(t[3]), longint'(t[4]), longint'(t[5])};
		c = '{longint'(t[6]), longint'(t[7]), longint'(t[8])};
		e1 = vsub(b, a);
		e2 = vsub(c, a);
		s = vsub(ray_org, a);
		n = vcross(e1, e2);
		q = vcross(s, ray_dir);
		den = sat32(vdot(ray_dir, n));
		nu = sat32(-vdot(q, e2));
		nv = sat32(vdot(q, e1));
		nt = sat32(-vdot(n, s));
		if (den == 0) return;
		rm = (64'd1 << 32) / ((den < 0) ? -den : den);
		recip = (den < 0) ? -longint'(rm) : longint'(rm);
		u = qmul(nu, recip);
		v = qmul(nv, recip);
		t_hit = qmul(nt, recip);
		if (u < 0 || u > ONE_Q || v < 0 || v > ONE_Q || u + v > ONE_Q) return;
		if (t_hit <= 0 || t_hit >= longint'(near_dist)) return;
		near_dist = t_hit[30:0];
		near_u = u;
		near_v = v;
		near_any = 1'b1;
	endtask

	task automatic close_ray();
		ray_result_t r;
		longint w;
		w = ONE_Q - near_u - near_v;
		r.hit = near_any;
		r.distance = near_dist;
		r.u = near_any ? near_u[16:0] : '0;
		r.v = near_any ? near_v[16:0] : '0;
		r.w = near_any ? w[16:0] : '0;
		pending_results.push_back(r);
		near_dist = dist_bound;
		near_u = 0;
		near_v = 0;
		near_any = 1'b0;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_ORIGIN_X: ray_org.x = longint'(signed'(data));
			CFG_ORIGIN_Y: ray_org.y = longint'(signed'(data));
			CFG_ORIGIN_Z: ray_org.z = longint'(signed'(data));
			CFG_DIR_X:    ray_dir.x = longint'(signed'(data));
			CFG_DIR_Y:    ray_dir.y = longint'(signed'(data));
			CFG_DIR_Z:    ray_dir.z = longint'(signed'(data));
			CFG_MAX_DIST: begin
				dist_bound = data[30:0];
				if (!near_any) near_dist = dist_bound;
			end
			default: ;
		endcase
	endtask

	// caller is idle; writes every ray register then drops the enable
	task automatic program_ray(vec3_t o, vec3_t d, logic [31:0] bound);
		write_reg(CFG_ORIGIN_X, o.x[31:0]);
		write_reg(CFG_ORIGIN_Y, o.y[31:0]);
		write_reg(CFG_ORIGIN_Z, o.z[31:0]);
		write_reg(CFG_DIR_X, d.x[31:0]);
		write_reg(CFG_DIR_Y, d.y[31:0]);
		write_reg(CFG_DIR_Z, d.z[31:0]);
		write_reg(CFG_MAX_DIST, bound);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_tri(tri_words_t t, bit last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		{a_x, a_y, a_z} <= {t[0], t[1], t[2]};
		{b_x, b_y, b_z} <= {t[3], t[4], t[5]};
		{c_x, c_y, c_z} <= {t[6], t[7], t[8]};
		last_triangle <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		tris_sent++;
		fold_triangle(t);
		if (last) close_ray();
	endtask

	// hold until every result word is back and the core has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		ray_result_t e;
		if (out_valid && out_ready) begin
			words_checked++;
			if (pending_results.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (hit) hits_seen++;
				if (hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, hit);
					errors++;
				end
				if (distance !== e.distance) begin
					$error("distance: expected %0h, got %0h", e.distance, distance);
					errors++;
				end
				if (bary_u !== e.u) begin
					$error("bary_u: expected %0h, got %0h", e.u, bary_u);
					errors++;
				end
				if (bary_v !== e.v) begin
					$error("bary_v: expected %0h, got %0h", e.v, bary_v);
					errors++;
				end
				if (bary_w !== e.w) begin
					$error("bary_w: expected %0h, got %0h", e.w, bary_w);
					errors++;
				end
			end
			out_stall = calm ? 0 : $urandom_range(0, 7);
		end
		if (!arst_n) out_ready <= 1'b0;
		else if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding",
				pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_default_ray();
		send_tri(tri9(2*ONE_Q, -ONE_Q, -ONE_Q, 2*ONE_Q, 2*ONE_Q, -ONE_Q,
			2*ONE_Q, -ONE_Q, 2*ONE_Q), 1'b1);
		send_tri(tri9(3*ONE_Q, 0, 0, 3*ONE_Q, ONE_Q, 0, 3*ONE_Q, 0, ONE_Q), 1'b1);
		send_tri(tri9(-2*ONE_Q, -ONE_Q, -ONE_Q, -2*ONE_Q, 2*ONE_Q, -ONE_Q,
			-2*ONE_Q, -ONE_Q, 2*ONE_Q), 1'b1);
	endtask

	task automatic test_extremes();
		logic signed [31:0] mx, mn;
		mx = 32'sh7FFFFFFF;
		mn = 32'sh80000000;
		send_tri(tri9(mx, mx, mx, mx, mx, mx, mx, mx, mx), 1'b0);
		send_tri(tri9(mn, mn, mn, mn, mn, mn, mn, mn, mn), 1'b0);
		send_tri(tri9(mn, mx, mn, mx, mn, mx, mn, mn, mx), 1'b0);
		send_tri(tri9(mx, mn, mx, mn, mx, mn, mx, mx, mn), 1'b1);
		// zero area triangle gives a zero denominator
		send_tri(tri9(ONE_Q, 0, 0, ONE_Q, 0, 0, ONE_Q, 0, 0), 1'b1);
	endtask

	task automatic test_equal_and_nearer();
		tri_words_t t;
		t = tri9(4*ONE_Q, -ONE_Q, -ONE_Q, 4*ONE_Q, 3*ONE_Q, -ONE_Q,
			4*ONE_Q, -ONE_Q, 3*ONE_Q);
		send_tri(t, 1'b0);
		send_tri(t, 1'b0);
		send_tri(tri9(ONE_Q, 0, 0, ONE_Q, ONE_Q, 0, ONE_Q, 0, ONE_Q), 1'b0);
		send_tri(t, 1'b1);
	endtask

	task automatic test_bound_and_ray_change();
		vec3_t o, d;
		o = '{0, 0, 0};
		d = '{ONE_Q, 0, 0};
		wait_idle();
		program_ray(o, d, 32'd0);
		send_tri(tri9(2*ONE_Q, -ONE_Q, -ONE_Q, 2*ONE_Q, 2*ONE_Q, -ONE_Q,
			2*ONE_Q, -ONE_Q, 2*ONE_Q), 1'b1);
		wait_idle();
		program_ray(o, d, 32'(3*ONE_Q));
		send_tri(tri9(5*ONE_Q, -ONE_Q, -ONE_Q, 5*ONE_Q, 2*ONE_Q, -ONE_Q,
			5*ONE_Q, -ONE_Q, 2*ONE_Q), 1'b0);
		send_tri(tri9(2*ONE_Q, -ONE_Q, -ONE_Q, 2*ONE_Q, 2*ONE_Q, -ONE_Q,
			2*ONE_Q, -ONE_Q, 2*ONE_Q), 1'b0);
		// change the ray while a hit is held
		wait_idle();
		d = '{-ONE_Q, 0, 0};
		program_ray(o, d, 32'h7FFFFFFF);
		send_tri(tri9(-ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q, 2*ONE_Q, -ONE_Q,
			-ONE_Q, -ONE_Q, 2*ONE_Q), 1'b1);
		wait_idle();
		write_reg(CFG_UNUSED, 32'hFFFFFFFF);
		cfg_we <= 1'b0;
		@(posedge clk);
		send_tri(tri9(-4*ONE_Q, 0, 0, -4*ONE_Q, ONE_Q, 0, -4*ONE_Q, 0, ONE_Q), 1'b1);
		wait_idle();
		program_ray('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF},
			'{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000}, 32'h7FFFFFFF);
		send_tri(tri9(0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q, 0), 1'b1);
	endtask

	function automatic longint spread(int lim);
		return longint'($urandom_range(0, 2*lim)) - lim;
	endfunction

	task automatic test_random(int total);
		vec3_t o, d;
		tri_words_t t;
		longint px, py, pz, depth;
		int count, n_tri;
		count = 0;
		while (count < total) begin
			wait_idle();
			calm = ($urandom_range(0, 3) == 0);
			o = '{spread(1 << 20), spread(1 << 20), spread(1 << 20)};
			d = '{spread(1 << 17), spread(1 << 17), spread(1 << 17)};
			program_ray(o, d, ($urandom_range(0, 5) == 0) ? $urandom() :
				32'(longint'($urandom_range(1, 40)) * ONE_Q));
			repeat (20) begin
				n_tri = $urandom_range(1, 6);
				for (int i = 0; i < n_tri; i++) begin
					if ($urandom_range(0, 9) < 8) begin
						depth = $urandom_range(1, 24 << 16);
						px = o.x + qmul(depth, d.x);
						py = o.y + qmul(depth, d.y);
						pz = o.z + qmul(depth, d.z);
						for (int k = 0; k < 3; k++) begin
							t[3*k]     = 32'(px + spread(4 << 16));
							t[3*k + 1] = 32'(py + spread(4 << 16));
							t[3*k + 2] = 32'(pz + spread(4 << 16));
						end
					end else begin
						foreach (t[k]) t[k] = $urandom();
					end
					send_tri(t, i == n_tri - 1);
					count++;
				end
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		ray_org = '{0, 0, 0};
		ray_dir = '{ONE_Q, 0, 0};
		dist_bound = 31'h7FFFFFFF;
		near_dist = dist_bound;
		near_u = 0;
		near_v = 0;
		near_any = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_ray();
		test_extremes();
		test_equal_and_nearer();
		test_bound_and_ray_change();
		test_random(1230);
		wait_idle();
		$display("Sent %0d triangles, checked %0d result words, %0d of them hits.",
			tris_sent, words_checked, hits_seen);
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/rtnh_pkg.sv
rtl/core/rtnh_ctrl.sv
rtl/core/rtnh_dp.sv
rtl/core/ray_triangle_nearest_hit_core.sv
sim/ray_triangle_nearest_hit_core_test.sv
